### rtl/core/bsfe_pkg.sv
// Package for the biquadratic shape function evaluator.
// Holds the transaction types, node constants, factor tables and width helpers.
// No dependencies.
package bsfe_pkg;

  localparam int NODE_W    = 4;
  localparam int NUM_NODES = 9;
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NUM_NODES - 1);

  typedef struct packed {
    logic signed [15:0] ref_x;
    logic signed [15:0] ref_y;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node_index;
    logic signed [15:0] shape_value;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic               last_node;
  } out_item_t;

  typedef enum logic [1:0] {
    FAC_P,
    FAC_Q,
    FAC_R
  } fac_e;

  function automatic fac_e fac_x_of(input logic [NODE_W-1:0] k);
    fac_e f;
    case (k)
      4'd0: f = FAC_P;
      4'd1: f = FAC_R;
      4'd2: f = FAC_R;
      4'd3: f = FAC_P;
      4'd4: f = FAC_Q;
      4'd5: f = FAC_R;
      4'd6: f = FAC_Q;
      4'd7: f = FAC_P;
      default: f = FAC_Q;
    endcase
    return f;
  endfunction

  function automatic fac_e fac_y_of(input logic [NODE_W-1:0] k);
    fac_e f;
    case (k)
      4'd0: f = FAC_P;
      4'd1: f = FAC_P;
      4'd2: f = FAC_R;
      4'd3: f = FAC_R;
      4'd4: f = FAC_P;
      4'd5: f = FAC_Q;
      4'd6: f = FAC_R;
      4'd7: f = FAC_Q;
      default: f = FAC_Q;
    endcase
    return f;
  endfunction

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // coordinate plus or minus one
  function automatic int tw_of(input int f);
    return imax(16, f + 1) + 1;
  endfunction

  // raw factor product
  function automatic int pw_of(input int f);
    return imax(2 * tw_of(f), 2 * f + 2);
  endfunction

  // rounded factor value
  function automatic int fw_of(input int f);
    return pw_of(f) + 1 - f;
  endfunction

  // exact factor derivative
  function automatic int dw_of(input int f);
    return imax(18, f + 2);
  endfunction

  function automatic int bw_of(input int f);
    return 6 * fw_of(f) + 6 * dw_of(f);
  endfunction

endpackage

### rtl/core/bsfe_front.sv
// Front end: takes a point and computes the P, Q, R factors and derivatives
// for both coordinates, then hands the bundle to the queue. Uses bsfe_pkg.
module bsfe_front
  import bsfe_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  in_item_t                   item_i,
  output logic                       busy_o,
  input  logic                       full_i,
  output logic                       push_o,
  output logic [bw_of(FRAC_BITS)-1:0] bundle_o
);

  localparam int F  = FRAC_BITS;
  localparam int TW = tw_of(F);
  localparam int PW = pw_of(F);
  localparam int FW = fw_of(F);
  localparam int DW = dw_of(F);

  localparam logic signed [TW-1:0] ONE_T  = TW'(1) << F;
  localparam logic signed [PW-1:0] ONE_SQ = PW'(1) << (2 * F);
  localparam logic signed [PW:0]   RND_H  = (PW + 1)'(1) << F;
  localparam logic signed [PW:0]   RND_Q  = (PW + 1)'(1) << (F - 1);
  localparam logic signed [DW-1:0] HALF_D = DW'(1) << (F - 1);

  logic               valid_q, valid_d;
  logic signed [15:0] x_q, y_q;
  logic               accept;

  assign busy_o = valid_q & full_i;
  assign accept = start_i & ~busy_o;
  assign push_o = valid_q & ~full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= item_i.ref_x;
      y_q <= item_i.ref_y;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_coord
    logic signed [TW-1:0] t, tm, tp;
    logic signed [PW-1:0] prod_p, prod_r, prod_sq, prod_q;
    logic signed [PW:0]   rnd_p, rnd_r, rnd_q;
    logic signed [DW-1:0] t_d;

    assign t  = (c == 0) ? TW'(x_q) : TW'(y_q);
    assign tm = t - ONE_T;
    assign tp = t + ONE_T;

    assign prod_p  = PW'(t) * PW'(tm);
    assign prod_r  = PW'(t) * PW'(tp);
    assign prod_sq = PW'(t) * PW'(t);
    assign prod_q  = ONE_SQ - prod_sq;

    assign rnd_p = ((PW + 1)'(prod_p) + RND_H) >>> (F + 1);
    assign rnd_r = ((PW + 1)'(prod_r) + RND_H) >>> (F + 1);
    assign rnd_q = ((PW + 1)'(prod_q) + RND_Q) >>> F;

    assign t_d = DW'(t);

    assign bundle_o[(3*c + 0)*FW +: FW] = FW'(rnd_p);
    assign bundle_o[(3*c + 1)*FW +: FW] = FW'(rnd_q);
    assign bundle_o[(3*c + 2)*FW +: FW] = FW'(rnd_r);
    assign bundle_o[6*FW + (3*c + 0)*DW +: DW] = t_d - HALF_D;
    assign bundle_o[6*FW + (3*c + 1)*DW +: DW] = -(t_d <<< 1);
    assign bundle_o[6*FW + (3*c + 2)*DW +: DW] = t_d + HALF_D;
  end

endmodule

### rtl/core/bsfe_queue.sv
// Two-entry queue between the front and back ends.
// Generic width; no package dependency.
module bsfe_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule

### rtl/core/bsfe_back.sv
// Back end: walks nodes 0..8 for the queue head, one per cycle while the queue is not
// empty, forms the three products, rounds and saturates. Uses bsfe_pkg.
module bsfe_back
  import bsfe_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  logic [bw_of(FRAC_BITS)-1:0] bundle_i,
  output logic                        pop_o,
  output logic                        valid_o,
  output out_item_t                   result_o
);

  localparam int F  = FRAC_BITS;
  localparam int FW = fw_of(F);
  localparam int DW = dw_of(F);
  localparam int MW = FW + imax(FW, DW);

  localparam logic signed [MW:0] RND  = (MW + 1)'(1) << (F - 1);
  localparam logic signed [MW:0] SMAX = (MW + 1)'(32767);
  localparam logic signed [MW:0] SMIN = -(MW + 1)'(32768);

  logic signed [FW-1:0] xv [3];
  logic signed [FW-1:0] yv [3];
  logic signed [DW-1:0] xd [3];
  logic signed [DW-1:0] yd [3];

  for (genvar f = 0; f < 3; f++) begin : g_unpack
    assign xv[f] = bundle_i[f*FW +: FW];
    assign yv[f] = bundle_i[(3 + f)*FW +: FW];
    assign xd[f] = bundle_i[6*FW + f*DW +: DW];
    assign yd[f] = bundle_i[6*FW + (3 + f)*DW +: DW];
  end

  logic [NODE_W-1:0]    k_q, k_d;
  fac_e                 sx, sy;
  logic signed [FW-1:0] fx, gy;
  logic signed [DW-1:0] dfx, dgy;

  logic                 s1_valid_q;
  logic [NODE_W-1:0]    s1_node_q;
  logic signed [MW-1:0] pv_q, pgx_q, pgy_q;

  logic                 valid_q;
  out_item_t            res_q, res_d;

  assign pop_o = ~empty_i && (k_q == LAST_NODE);
  assign sx    = fac_x_of(k_q);
  assign sy    = fac_y_of(k_q);

  always_comb begin
    case (sx)
      FAC_P: begin
        fx  = xv[0];
        dfx = xd[0];
      end
      FAC_R: begin
        fx  = xv[2];
        dfx = xd[2];
      end
      default: begin
        fx  = xv[1];
        dfx = xd[1];
      end
    endcase
    case (sy)
      FAC_P: begin
        gy  = yv[0];
        dgy = yd[0];
      end
      FAC_R: begin
        gy  = yv[2];
        dgy = yd[2];
      end
      default: begin
        gy  = yv[1];
        dgy = yd[1];
      end
    endcase
  end

  always_comb begin
    k_d = k_q;
    if (!empty_i) begin
      k_d = (k_q == LAST_NODE) ? '0 : k_q + NODE_W'(1);
    end
  end

  function automatic logic signed [15:0] rnd_sat(input logic signed [MW-1:0] p);
    logic signed [MW:0] s;
    s = ((MW + 1)'(p) + RND) >>> F;
    if (s > SMAX) begin
      return 16'sh7fff;
    end else if (s < SMIN) begin
      return -16'sh8000;
    end
    return 16'(s);
  endfunction

  always_comb begin
    res_d.node_index  = s1_node_q;
    res_d.shape_value = rnd_sat(pv_q);
    res_d.grad_x      = rnd_sat(pgx_q);
    res_d.grad_y      = rnd_sat(pgy_q);
    res_d.last_node   = s1_node_q == LAST_NODE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      s1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      k_q        <= k_d;
      s1_valid_q <= ~empty_i;
      valid_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_node_q <= k_q;
    pv_q      <= MW'(fx) * MW'(gy);
    pgx_q     <= MW'(dfx) * MW'(gy);
    pgy_q     <= MW'(fx) * MW'(dgy);
    res_q     <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= LAST_NODE)
    else $error("node counter out of range");

  a_node_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.last_node |=> valid_o &&
      result_o.node_index == $past(result_o.node_index) + NODE_W'(1))
    else $error("node results not contiguous");

endmodule

### rtl/core/biquadratic_shape_function_eval_unit.sv
// Biquadratic shape function evaluator, top level.
// Points are registered, then queued; nodes pass the product and result registers.
// The back end issues one node a cycle while the queue holds a point.
// busy is high while the front end holds a point and the two-entry queue is full.
// Reset clears all valid flags and the node counter; results cannot be stalled.
module biquadratic_shape_function_eval_unit
  import bsfe_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_item_t  item_i,
  output logic      busy,
  output logic      result_valid_o,
  output out_item_t result_o
);

  localparam int BW = bw_of(FRAC_BITS);

  logic          full, empty, push, pop;
  logic [BW-1:0] bundle_in, bundle_out;

  bsfe_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (item_i),
    .busy_o  (busy),
    .full_i  (full),
    .push_o  (push),
    .bundle_o(bundle_in)
  );

  bsfe_queue #(
    .WIDTH(BW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (bundle_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (bundle_out)
  );

  bsfe_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .bundle_i(bundle_out),
    .pop_o   (pop),
    .valid_o (result_valid_o),
    .result_o(result_o)
  );

endmodule

### sim/bsfe_result_checker.sv
// Result checker for the biquadratic shape function evaluator.
// Predicts the nine node results of each accepted point and compares them in order.
// Depends on bsfe_pkg for the transaction types and factor kinds.
module bsfe_result_checker
  import bsfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  in_item_t  item_i,
  input  logic      result_valid_i,
  input  out_item_t result_i,
  output int        mismatches_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 14;

  localparam fac_e X_FACTOR [NUM_NODES] = '{FAC_P, FAC_R, FAC_R, FAC_P, FAC_Q,
                                            FAC_R, FAC_Q, FAC_P, FAC_Q};
  localparam fac_e Y_FACTOR [NUM_NODES] = '{FAC_P, FAC_P, FAC_R, FAC_R, FAC_P,
                                            FAC_Q, FAC_R, FAC_Q, FAC_Q};

  out_item_t node_results_q[$];
  int        mismatches = 0;

  assign mismatches_o = mismatches;

  // round to nearest, ties towards plus infinity
  function automatic longint round_frac(longint n, int k);
    return (n + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [15:0] clamp_word(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic longint lagrange_1d(fac_e f, longint t);
    longint one = longint'(1) <<< FB;
    case (f)
      FAC_P: return round_frac(t * (t - one), FB + 1);
      FAC_Q: return round_frac(one * one - t * t, FB);
      default: return round_frac(t * (t + one), FB + 1);
    endcase
  endfunction

  function automatic longint lagrange_1d_slope(fac_e f, longint t);
    longint half = longint'(1) <<< (FB - 1);
    case (f)
      FAC_P: return t - half;
      FAC_Q: return -2 * t;
      default: return t + half;
    endcase
  endfunction

  function automatic logic signed [15:0] fixed_product(longint a, longint b);
    return clamp_word(round_frac(a * b, FB));
  endfunction

  task automatic predict_nodes(in_item_t pt);
    longint    x;
    longint    y;
    longint    fx;
    longint    gy;
    out_item_t r;
    x = longint'(pt.ref_x);
    y = longint'(pt.ref_y);
    for (int k = 0; k < NUM_NODES; k++) begin
      fx = lagrange_1d(X_FACTOR[k], x);
      gy = lagrange_1d(Y_FACTOR[k], y);
      r.node_index  = NODE_W'(k);
      r.shape_value = fixed_product(fx, gy);
      r.grad_x      = fixed_product(lagrange_1d_slope(X_FACTOR[k], x), gy);
      r.grad_y      = fixed_product(fx, lagrange_1d_slope(Y_FACTOR[k], y));
      r.last_node   = (k == NUM_NODES - 1);
      node_results_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (node_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result node %0d value %0d gx %0d gy %0d last %0b",
                     $realtime, result_i.node_index, result_i.shape_value,
                     result_i.grad_x, result_i.grad_y, result_i.last_node);
          mismatches++;
        end else begin
          want = node_results_q.pop_front();
          if (result_i.node_index !== want.node_index ||
              result_i.shape_value !== want.shape_value ||
              result_i.grad_x !== want.grad_x ||
              result_i.grad_y !== want.grad_y ||
              result_i.last_node !== want.last_node) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp n%0d v%0d gx%0d gy%0d l%0b got n%0d v%0d gx%0d gy%0d l%0b",
                       $realtime, want.node_index, want.shape_value, want.grad_x,
                       want.grad_y, want.last_node, result_i.node_index,
                       result_i.shape_value, result_i.grad_x, result_i.grad_y,
                       result_i.last_node);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i)
        predict_nodes(item_i);
    end
    pending_o <= node_results_q.size();
  end

endmodule

### sim/testbench.sv
// Top of the shape function evaluator testbench: clock, reset, point stimulus, verdict.
// Drives directed and random points with varying idle gaps into the unit.
// Depends on bsfe_pkg, biquadratic_shape_function_eval_unit and bsfe_result_checker.
module testbench
  import bsfe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 16384;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  in_item_t  item_i;
  logic      busy;
  logic      result_valid_o;
  out_item_t result_o;
  int        mismatches;
  int        pending;

  biquadratic_shape_function_eval_unit #(.FRAC_BITS(14)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  bsfe_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // called just after a falling edge; returns just after a falling edge
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start        <= 1'b1;
    item_i.ref_x <= x;
    item_i.ref_y <= y;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] random_coord();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(6))
        0: return 16'sd0;
        1: return 16'(ONE);
        2: return 16'(-ONE);
        3: return 16'(ONE / 2);
        4: return 16'(-ONE / 2);
        5: return 16'sd1;
        default: return -16'sd1;
      endcase
    end
    if (r < 14) return 16'($urandom);
    return 16'(int'($urandom_range(2 * ONE)) - ONE);
  endfunction

  initial begin
    int dir_x [20];
    int dir_y [20];
    int idle_by_phase [4];

    dir_x = '{0, -ONE, ONE, ONE, -ONE, 0, ONE, 0, -ONE, ONE / 2,
              -ONE / 2, 1, ONE - 1, 32767, -32768, -32768, 32767, 10922, -10923, ONE};
    dir_y = '{0, -ONE, -ONE, ONE, ONE, -ONE, 0, ONE, 0, -ONE / 2,
              ONE / 2, -1, 1 - ONE, -32768, 32767, -32768, 32767, 5461, 21845, -1};
    idle_by_phase = '{0, 58, 14, 0};

    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 20; i++)
      send_point(16'(dir_x[i]), 16'(dir_y[i]), 0);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 110; i++)
        send_point(random_coord(), random_coord(), idle_by_phase[p]);
      drain_results();
    end

    repeat (16) @(negedge clk_i);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
